// File: hdl/dns_query_encoder_top_defines.svh
// assertion macros used by the checker file
`ifndef DNS_QUERY_ENCODER_TOP_DEFINES_SVH
`define DNS_QUERY_ENCODER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DQE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DQE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/dqe_pkg.sv
package dqe_pkg;

   // name limits
   localparam int unsigned MAX_LABEL   = 63;
   localparam int unsigned MAX_NAME    = 255;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0]  DOT_CHAR    = 8'h2E;
   localparam logic [8:0]  HDR_LEN     = 9'd12;
   localparam logic [3:0]  HDR_LAST    = 4'd11;
   localparam logic [3:0]  TRL_LAST    = 4'd4;
   localparam logic [3:0]  TRL_QTYPE   = 4'd2;
   localparam logic [8:0]  TRL_LEN     = 9'd5;
   localparam logic [7:0]  QTYPE_A     = 8'h01;
   localparam logic [7:0]  QTYPE_AAAA  = 8'h1C;
   localparam logic [7:0]  QCLASS_IN   = 8'h01;
   localparam logic [15:0] BUF_RESET   = 16'd512;
   localparam logic [16:0] FIXED_BYTES = 17'd18;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_BUFFER = 2'd1,
      ERR_LABEL  = 2'd2,
      ERR_NAME   = 2'd3
   } err_type;

   typedef enum logic {
      CSR_QTYPE    = 1'b0,
      CSR_BUF_SIZE = 1'b1
   } csr_index_type;

   // one accepted character, reduced to the writes it causes
   typedef struct packed {
      logic       hdr;
      logic       skip_id;
      logic       chr_vld;
      logic [8:0] chr_off;
      logic [7:0] chr_byte;
      logic       len_vld;
      logic [8:0] len_off;
      logic [7:0] len_byte;
      logic       trl_vld;
      logic [8:0] trl_base;
      logic       trl_ipv6;
      logic       sts_vld;
      err_type    sts_err;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   // fixed header: id 0, flags rd, qdcount 1, other counts 0
   function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd2, 4'd5: b = 8'h01;
         default:    b = 8'h00;
      endcase
      return b;
   endfunction

   // zero terminator, qtype, qclass
   function automatic logic [7:0] trl_byte(input logic [3:0] idx, input logic ipv6);
      logic [7:0] b;
      case (idx)
         TRL_QTYPE: b = ipv6 ? QTYPE_AAAA : QTYPE_A;
         TRL_LAST:  b = QCLASS_IN;
         default:   b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: hdl/dqe_front.sv
module dqe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_host_char,
   input  logic               req_final_char,
   input  logic               csr_wen,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               q_full,
   output dqe_pkg::push_type  push
);

   logic             qtype_ff, qtype_in;
   logic [15:0]      buf_size_ff, buf_size_in;
   logic             in_name_ff, in_name_in;
   logic [8:0]       label_start_ff, label_start_in;
   logic [6:0]       label_len_ff, label_len_in;
   logic [8:0]       octet_total_ff, octet_total_in;
   logic [15:0]      char_total_ff, char_total_in;
   dqe_pkg::err_type first_err_ff, first_err_in;

   logic             accept, is_dot, fin, chr_path, close, name_err;
   logic [8:0]       cur_ls, cur_ot, ot_new;
   logic [6:0]       cur_ll, ll_a;
   logic [15:0]      cur_ct, ct_new;
   logic [9:0]       ot_sum;
   logic [16:0]      buf_need;
   dqe_pkg::err_type cur_err, err_a, err_f;
   dqe_pkg::job_type job;

   always_comb begin
      qtype_in    = qtype_ff;
      buf_size_in = buf_size_ff;
      if (csr_wen) begin
         case (dqe_pkg::csr_index_type'(csr_index))
            dqe_pkg::CSR_QTYPE:    qtype_in    = csr_wdata[0];
            dqe_pkg::CSR_BUF_SIZE: buf_size_in = csr_wdata;
            default:               qtype_in    = qtype_ff;
         endcase
      end
   end

   always_comb begin
      req_ready = !q_full;
      accept    = req_valid && !q_full;
      is_dot    = (req_host_char == dqe_pkg::DOT_CHAR);
      fin       = req_final_char;

      // a new name starts from cleared state
      cur_ls  = in_name_ff ? label_start_ff : dqe_pkg::HDR_LEN;
      cur_ll  = in_name_ff ? label_len_ff   : 7'd0;
      cur_ot  = in_name_ff ? octet_total_ff : 9'd0;
      cur_ct  = in_name_ff ? char_total_ff  : 16'd0;
      cur_err = in_name_ff ? first_err_ff   : dqe_pkg::ERR_NONE;

      ct_new = (cur_ct == 16'hFFFF) ? cur_ct : cur_ct + 16'd1;

      chr_path = !is_dot && (cur_err == dqe_pkg::ERR_NONE);
      ll_a     = (chr_path && (cur_ll != 7'h7F)) ? cur_ll + 7'd1 : cur_ll;

      job          = '0;
      job.hdr      = !in_name_ff;
      job.skip_id  = fin && !is_dot;
      job.chr_vld  = chr_path && (cur_ll < 7'(dqe_pkg::MAX_LABEL))
                     && ((10'(cur_ot) + 10'(cur_ll) + 10'd1) < 10'(dqe_pkg::MAX_NAME));
      job.chr_off  = cur_ls + 9'd1 + 9'(cur_ll);
      job.chr_byte = req_host_char;

      close        = (is_dot || fin) && (cur_err == dqe_pkg::ERR_NONE);
      job.len_vld  = close && (ll_a <= 7'(dqe_pkg::MAX_LABEL));
      job.len_off  = cur_ls;
      job.len_byte = 8'(ll_a);

      ot_sum   = 10'(cur_ot) + 10'(ll_a) + 10'd1;
      ot_new   = job.len_vld ? ot_sum[8:0] : cur_ot;
      name_err = job.len_vld && (ot_sum > 10'(dqe_pkg::MAX_NAME));

      if (close && !job.len_vld) begin
         err_a = dqe_pkg::ERR_LABEL;
      end else if (name_err) begin
         err_a = dqe_pkg::ERR_NAME;
      end else begin
         err_a = cur_err;
      end

      buf_need = 17'(ct_new) + dqe_pkg::FIXED_BYTES;
      err_f    = ({1'b0, buf_size_ff} < buf_need) ? dqe_pkg::ERR_BUFFER : err_a;

      job.trl_vld  = fin && (err_f == dqe_pkg::ERR_NONE);
      job.trl_base = dqe_pkg::HDR_LEN + ot_new;
      job.trl_ipv6 = qtype_ff;
      job.sts_vld  = fin && (err_f != dqe_pkg::ERR_NONE);
      job.sts_err  = err_f;

      push.valid = accept && (job.hdr || job.chr_vld || job.len_vld || fin);
      push.job   = job;

      in_name_in     = in_name_ff;
      label_start_in = label_start_ff;
      label_len_in   = label_len_ff;
      octet_total_in = octet_total_ff;
      char_total_in  = char_total_ff;
      first_err_in   = first_err_ff;
      if (accept) begin
         in_name_in     = !fin;
         octet_total_in = ot_new;
         char_total_in  = ct_new;
         first_err_in   = err_a;
         if (job.len_vld && !name_err) begin
            label_start_in = dqe_pkg::HDR_LEN + ot_new;
            label_len_in   = 7'd0;
         end else begin
            label_start_in = cur_ls;
            label_len_in   = ll_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qtype_ff       <= 1'b0;
         buf_size_ff    <= dqe_pkg::BUF_RESET;
         in_name_ff     <= 1'b0;
         label_start_ff <= dqe_pkg::HDR_LEN;
         label_len_ff   <= 7'd0;
         octet_total_ff <= 9'd0;
         char_total_ff  <= 16'd0;
         first_err_ff   <= dqe_pkg::ERR_NONE;
      end else begin
         qtype_ff       <= qtype_in;
         buf_size_ff    <= buf_size_in;
         in_name_ff     <= in_name_in;
         label_start_ff <= label_start_in;
         label_len_ff   <= label_len_in;
         octet_total_ff <= octet_total_in;
         char_total_ff  <= char_total_in;
         first_err_ff   <= first_err_in;
      end
   end

endmodule

// File: hdl/dqe_queue.sv
module dqe_queue #(
   parameter int unsigned DEPTH = dqe_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  dqe_pkg::push_type push,
   output logic              full,
   output dqe_pkg::head_type head,
   input  logic              pop
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   dqe_pkg::job_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      full       = (count_ff == CNT_W'(DEPTH));
      head.valid = (count_ff != '0);
      head.job   = slot_ff[rd_ptr_ff];
      do_push    = push.valid && !full;
      do_pop     = pop && head.valid;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end

      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/dqe_back.sv
module dqe_back (
   input  logic              clock,
   input  logic              reset,
   input  dqe_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [8:0]        rsp_write_offset,
   output logic [7:0]        rsp_write_byte,
   output logic              rsp_write_valid,
   output logic              rsp_done_res,
   output logic [1:0]        rsp_error_code,
   output logic [8:0]        rsp_packet_length
);

   typedef enum logic [4:0] {
      PH_HDR = 5'b00001,
      PH_CHR = 5'b00010,
      PH_LEN = 5'b00100,
      PH_TRL = 5'b01000,
      PH_STS = 5'b10000
   } phase_type;

   logic        start_ff, start_in;
   logic [4:0]  remain_ff, remain_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [8:0]  rsp_off_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_wv_ff;
   logic        rsp_done_ff;
   logic [1:0]  rsp_err_ff;
   logic [8:0]  rsp_len_ff;

   logic [4:0]  active, lowest, left;
   phase_type   phase;
   logic [3:0]  hdr_idx;
   logic        last, load;
   logic [8:0]  r_off, r_len;
   logic [7:0]  r_byte;
   logic        r_wv, r_done;
   logic [1:0]  r_err;

   always_comb begin
      // remaining parts of the head request, lowest first
      active = start_ff ? {head.job.sts_vld, head.job.trl_vld, head.job.len_vld,
                           head.job.chr_vld, head.job.hdr}
                        : remain_ff;
      lowest = active & (~active + 5'd1);
      left   = active & ~lowest;
      phase  = phase_type'(lowest);
      hdr_idx = cnt_ff + {2'b00, head.job.skip_id, 1'b0};

      r_off  = 9'd0;
      r_byte = 8'd0;
      r_wv   = 1'b1;
      r_done = 1'b0;
      r_err  = dqe_pkg::ERR_NONE;
      r_len  = 9'd0;
      last   = 1'b1;
      case (phase)
         PH_HDR: begin
            r_off  = 9'(hdr_idx);
            r_byte = dqe_pkg::hdr_byte(hdr_idx);
            last   = (hdr_idx == dqe_pkg::HDR_LAST);
         end
         PH_CHR: begin
            r_off  = head.job.chr_off;
            r_byte = head.job.chr_byte;
         end
         PH_LEN: begin
            r_off  = head.job.len_off;
            r_byte = head.job.len_byte;
         end
         PH_TRL: begin
            r_off  = head.job.trl_base + 9'(cnt_ff);
            r_byte = dqe_pkg::trl_byte(cnt_ff, head.job.trl_ipv6);
            last   = (cnt_ff == dqe_pkg::TRL_LAST);
            r_done = last;
            r_len  = last ? head.job.trl_base + dqe_pkg::TRL_LEN : 9'd0;
         end
         PH_STS: begin
            r_wv   = 1'b0;
            r_done = 1'b1;
            r_err  = head.job.sts_err;
         end
         default: begin
            r_wv = 1'b0;
         end
      endcase

      load = head.valid && (!rsp_valid_ff || rsp_ready);
      pop  = load && last && (left == 5'd0);

      start_in  = start_ff;
      remain_in = remain_ff;
      cnt_in    = cnt_ff;
      if (load) begin
         if (last) begin
            cnt_in    = 4'd0;
            start_in  = (left == 5'd0);
            remain_in = left;
         end else begin
            cnt_in    = cnt_ff + 4'd1;
            start_in  = 1'b0;
            remain_in = active;
         end
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b1;
         remain_ff    <= 5'd0;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         remain_ff    <= remain_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_off_ff  <= r_off;
         rsp_byte_ff <= r_byte;
         rsp_wv_ff   <= r_wv;
         rsp_done_ff <= r_done;
         rsp_err_ff  <= r_err;
         rsp_len_ff  <= r_len;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_offset  = rsp_off_ff;
   assign rsp_write_byte    = rsp_byte_ff;
   assign rsp_write_valid   = rsp_wv_ff;
   assign rsp_done_res      = rsp_done_ff;
   assign rsp_error_code    = rsp_err_ff;
   assign rsp_packet_length = rsp_len_ff;

endmodule

// File: hdl/dns_query_encoder_top.sv
// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------------------
// request   | req_valid / req_ready  | req_host_char, req_final_char
// response  | rsp_valid / rsp_ready  | rsp_write_offset, rsp_write_byte,
//           |                        | rsp_write_valid, rsp_done_res,
//           |                        | rsp_error_code, rsp_packet_length
// csr       | csr_wen                | csr_index, csr_wdata
//
// one request per cycle while the job queue has room; a request that
// causes one write (a plain character) holds that rate while rsp_ready is high
// the back end emits one response per cycle while rsp_ready is high, so the
// first character adds the header writes and the final one the trailer or status
// first response passes the queue slot and the output register; no clearing pass
// synchronous active-high reset; req_ready drops only when the queue is full
// a stalled response holds in the output register while the queue fills
module dns_query_encoder_top #(
   parameter int unsigned QUEUE_DEPTH = dqe_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_host_char,
   input  logic        req_final_char,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [8:0]  rsp_write_offset,
   output logic [7:0]  rsp_write_byte,
   output logic        rsp_write_valid,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_error_code,
   output logic [8:0]  rsp_packet_length,
   // register writes, to be made only while idle; the block does not enforce this
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // front to queue: one job per accepted character that causes writes or a status
   dqe_pkg::push_type push;
   logic              q_full;
   // queue to back: oldest job, popped when its last response is loaded
   dqe_pkg::head_type head;
   logic              pop;

   // tracks label and name state, checks limits, builds the job
   dqe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_host_char  (req_host_char),
      .req_final_char (req_final_char),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_full         (q_full),
      .push           (push)
   );

   // short job queue, decouples the character stream from write bursts
   dqe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .head  (head),
      .pop   (pop)
   );

   // walks each job: header, character, length byte, trailer or status
   dqe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_offset  (rsp_write_offset),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_done_res      (rsp_done_res),
      .rsp_error_code    (rsp_error_code),
      .rsp_packet_length (rsp_packet_length)
   );

endmodule

// File: hdl/dqe_checker.sv
`include "dns_query_encoder_top_defines.svh"

module dqe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [8:0]  rsp_write_offset,
   input logic [7:0]  rsp_write_byte,
   input logic        rsp_write_valid,
   input logic        rsp_done_res,
   input logic [1:0]  rsp_error_code,
   input logic [8:0]  rsp_packet_length
);

   // a stalled response keeps its write
   `DQE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_write_offset) && $stable(rsp_write_byte), "response changed while stalled")

   // a status-only response ends a query with an error
   `DQE_ASSERT_SAME(a_status_err, rsp_valid && !rsp_write_valid, rsp_done_res && rsp_error_code != dqe_pkg::ERR_NONE, "status response without error")

   // an error carries no write and no length
   `DQE_ASSERT_SAME(a_err_clean, rsp_valid && rsp_error_code != dqe_pkg::ERR_NONE, !rsp_write_valid && rsp_packet_length == 9'd0, "error response with write or length")

   // a good query ends on the qclass byte, the last byte of the packet
   `DQE_ASSERT_SAME(a_done_len, rsp_valid && rsp_done_res && rsp_write_valid, rsp_packet_length == rsp_write_offset + 9'd1, "packet length off the last write")

endmodule

bind dns_query_encoder_top dqe_checker u_checker (.*);

// File: sim/dns_query_encoder_top_tb.sv
`timescale 1ns / 1ps

module dns_query_encoder_top_tb;

   // one host name character as the sender presents it
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } host_item_type;

   // one packet store write, or a status-only response
   typedef struct packed {
      logic [8:0]       offset;
      logic [7:0]       data;
      logic             wvalid;
      logic             done;
      dqe_pkg::err_type err;
      logic [8:0]       plen;
   } store_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_host_char = 8'h00;
   logic        req_final_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [8:0]  rsp_write_offset;
   logic [7:0]  rsp_write_byte;
   logic        rsp_write_valid;
   logic        rsp_done_res;
   logic [1:0]  rsp_error_code;
   logic [8:0]  rsp_packet_length;
   logic        csr_wen = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;

   // characters waiting to be sent, and writes the encoder still owes us
   host_item_type   chars_to_send[$];
   store_write_type writes_due[$];

   // idle odds in percent, changed between phases only
   int unsigned snd_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;

   int unsigned items_queued = 0;
   int unsigned reqs_sent = 0;
   int unsigned rsps_checked = 0;
   int unsigned queries_done = 0;
   int unsigned queries_failed = 0;
   int unsigned fails = 0;

   // encoder image: register copies and the state of the name being built
   logic             cfg_ipv6;
   logic [15:0]      cfg_buf_size;
   logic             nm_open;
   logic [8:0]       lbl_start;
   logic [6:0]       lbl_len;
   logic [8:0]       nm_octets;
   logic [15:0]      nm_chars;
   dqe_pkg::err_type nm_err;

   dns_query_encoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_host_char     (req_host_char),
      .req_final_char    (req_final_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_write_offset  (rsp_write_offset),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_done_res      (rsp_done_res),
      .rsp_error_code    (rsp_error_code),
      .rsp_packet_length (rsp_packet_length),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   function automatic void reset_name();
      nm_open   = 1'b0;
      lbl_start = dqe_pkg::HDR_LEN;
      lbl_len   = 7'd0;
      nm_octets = 9'd0;
      nm_chars  = 16'd0;
      nm_err    = dqe_pkg::ERR_NONE;
   endfunction

   function automatic void push_write(input logic [8:0] off, input logic [7:0] val,
                                      input logic wv, input logic dn,
                                      input dqe_pkg::err_type e, input logic [8:0] plen);
      store_write_type w;
      w.offset = off;
      w.data   = val;
      w.wvalid = wv;
      w.done   = dn;
      w.err    = e;
      w.plen   = plen;
      writes_due.push_back(w);
   endfunction

   // works out every write that one accepted character causes
   function automatic void encode_char(input logic [7:0] c, input logic fin);
      int unsigned      i;
      int unsigned      first;
      logic [8:0]       tail;
      dqe_pkg::err_type e;
      // first character of a name: header, minus the id when the name is one non-dot character
      if (!nm_open) begin
         first = (fin && c != dqe_pkg::DOT_CHAR) ? 2 : 0;
         reset_name();
         nm_open = 1'b1;
         for (i = first; i < dqe_pkg::HDR_LEN; i++)
            push_write(9'(i), (i == 2 || i == 5) ? 8'h01 : 8'h00, 1'b1, 1'b0,
                       dqe_pkg::ERR_NONE, 9'd0);
      end
      if (nm_chars != 16'hFFFF) nm_chars++;
      // label character, dropped once it can no longer fit
      if (c != dqe_pkg::DOT_CHAR && nm_err == dqe_pkg::ERR_NONE) begin
         if (lbl_len < dqe_pkg::MAX_LABEL && nm_octets + 1 + lbl_len < dqe_pkg::MAX_NAME)
            push_write(9'(lbl_start + 1 + lbl_len), c, 1'b1, 1'b0, dqe_pkg::ERR_NONE, 9'd0);
         if (lbl_len != 7'd127) lbl_len++;
      end
      // label close: length byte, then the name length check
      if ((c == dqe_pkg::DOT_CHAR || fin) && nm_err == dqe_pkg::ERR_NONE) begin
         if (lbl_len > dqe_pkg::MAX_LABEL) begin
            nm_err = dqe_pkg::ERR_LABEL;
         end else begin
            push_write(lbl_start, {1'b0, lbl_len}, 1'b1, 1'b0, dqe_pkg::ERR_NONE, 9'd0);
            nm_octets = 9'(nm_octets + 1 + lbl_len);
            if (nm_octets > dqe_pkg::MAX_NAME) begin
               nm_err = dqe_pkg::ERR_NAME;
            end else begin
               lbl_start = dqe_pkg::HDR_LEN + nm_octets;
               lbl_len   = 7'd0;
            end
         end
      end
      // end of name: buffer check wins over any earlier error
      if (fin) begin
         e = nm_err;
         if (cfg_buf_size < dqe_pkg::FIXED_BYTES + nm_chars) e = dqe_pkg::ERR_BUFFER;
         if (e != dqe_pkg::ERR_NONE) begin
            push_write(9'd0, 8'h00, 1'b0, 1'b1, e, 9'd0);
         end else begin
            tail = dqe_pkg::HDR_LEN + nm_octets;
            push_write(tail, 8'h00, 1'b1, 1'b0, dqe_pkg::ERR_NONE, 9'd0);
            push_write(tail + 9'd1, 8'h00, 1'b1, 1'b0, dqe_pkg::ERR_NONE, 9'd0);
            push_write(tail + 9'd2, cfg_ipv6 ? dqe_pkg::QTYPE_AAAA : dqe_pkg::QTYPE_A,
                       1'b1, 1'b0, dqe_pkg::ERR_NONE, 9'd0);
            push_write(tail + 9'd3, 8'h00, 1'b1, 1'b0, dqe_pkg::ERR_NONE, 9'd0);
            push_write(tail + 9'd4, dqe_pkg::QCLASS_IN, 1'b1, 1'b1, dqe_pkg::ERR_NONE,
                       tail + dqe_pkg::TRL_LEN);
         end
         reset_name();
      end
   endfunction

   // ------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------

   always @(posedge clock) begin : req_drv
      host_item_type nxt;
      if (reset) begin
         req_valid      <= 1'b0;
         req_host_char  <= 8'h00;
         req_final_char <= 1'b0;
      end else begin
         // request taken at this edge: predict its writes
         if (req_valid && req_ready) begin
            encode_char(req_host_char, req_final_char);
            reqs_sent++;
         end
         // a request not yet taken holds valid and payload
         if (!req_valid || req_ready) begin
            if (chars_to_send.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
               nxt = chars_to_send.pop_front();
               req_valid      <= 1'b1;
               req_host_char  <= nxt.ch;
               req_final_char <= nxt.fin;
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // response monitor
   // ------------------------------------------------------------------

   function automatic bit check_field(input string fname, input logic [15:0] want,
                                      input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", fname, want, got);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : rsp_mon
      store_write_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsps_checked++;
            if (rsp_done_res) begin
               queries_done++;
               if (rsp_error_code != dqe_pkg::ERR_NONE) queries_failed++;
            end
            if (writes_due.size() == 0) begin
               $error("response with nothing outstanding: offset %0d byte %0d",
                      rsp_write_offset, rsp_write_byte);
               fails++;
            end else begin
               want = writes_due.pop_front();
               fails += check_field("write_offset", 16'(want.offset), 16'(rsp_write_offset));
               fails += check_field("write_byte", 16'(want.data), 16'(rsp_write_byte));
               fails += check_field("write_valid", 16'(want.wvalid), 16'(rsp_write_valid));
               fails += check_field("done_res", 16'(want.done), 16'(rsp_done_res));
               fails += check_field("error_code", 16'(want.err), 16'(rsp_error_code));
               fails += check_field("packet_length", 16'(want.plen),
                                    16'(rsp_packet_length));
            end
         end
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   function automatic void queue_item(input logic [7:0] ch, input logic fin);
      host_item_type it;
      it.ch  = ch;
      it.fin = fin;
      chars_to_send.push_back(it);
      items_queued++;
   endfunction

   function automatic void queue_text(input string s);
      int j;
      for (j = 0; j < s.len(); j++)
         queue_item(s[j], j == s.len() - 1);
   endfunction

   // any byte but the separator
   function automatic logic [7:0] random_label_char();
      logic [7:0] c;
      c = 8'($urandom_range(255));
      if (c == dqe_pkg::DOT_CHAR) c = $urandom_range(1) ? 8'h2D : 8'hAE;
      return c;
   endfunction

   // mostly well-formed names with random bytes; some noise, some over-long labels
   function automatic void queue_host_name();
      logic [7:0]  name_q[$];
      int unsigned roll;
      int unsigned nlab;
      int unsigned len;
      int unsigned k;
      int unsigned j;
      roll = $urandom_range(99);
      if (roll < 12) begin
         // noise: dots anywhere, empty labels, leading and trailing dots
         len = $urandom_range(1, 12);
         for (j = 0; j < len; j++)
            name_q.push_back(($urandom_range(3) == 0) ? dqe_pkg::DOT_CHAR
                                                      : 8'($urandom_range(255)));
      end else begin
         nlab = $urandom_range(1, 4);
         for (k = 0; k < nlab; k++) begin
            if (k != 0) name_q.push_back(dqe_pkg::DOT_CHAR);
            // a few first labels straddle the label limit
            len = (roll < 20 && k == 0) ? $urandom_range(60, 68) : $urandom_range(0, 9);
            for (j = 0; j < len; j++) name_q.push_back(random_label_char());
         end
         if ($urandom_range(4) == 0) name_q.push_back(dqe_pkg::DOT_CHAR);
      end
      if (name_q.size() == 0) name_q.push_back(random_label_char());
      for (j = 0; j < name_q.size(); j++)
         queue_item(name_q[j], j == name_q.size() - 1);
   endfunction

   task automatic write_reg(input dqe_pkg::csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         dqe_pkg::CSR_QTYPE:    cfg_ipv6 = val[0];
         dqe_pkg::CSR_BUF_SIZE: cfg_buf_size = val;
         default:               cfg_ipv6 = cfg_ipv6;
      endcase
   endtask

   // sender holds off until every write has come back, then a latency margin
   task automatic wait_drained();
      do
         @(negedge clock);
      while (chars_to_send.size() != 0 || req_valid || writes_due.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic run_phase(input logic ipv6, input logic [15:0] bsize,
                            input int unsigned snd, input int unsigned rcv,
                            input int unsigned n_items);
      int unsigned start;
      write_reg(dqe_pkg::CSR_QTYPE, {15'd0, ipv6});
      write_reg(dqe_pkg::CSR_BUF_SIZE, bsize);
      snd_idle_pct = snd;
      rcv_idle_pct = rcv;
      @(negedge clock);
      start = items_queued;
      while (items_queued - start < n_items) queue_host_name();
      wait_drained();
   endtask

   initial begin
      cfg_ipv6     = 1'b0;
      cfg_buf_size = dqe_pkg::BUF_RESET;
      reset_name();
      snd_idle_pct = 28;
      rcv_idle_pct = 84;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset settings: one-character name, lone dot, plain labels,
      // leading dot, empty inner label, trailing dot, extreme byte values
      queue_text("a");
      queue_text(".");
      queue_text("ab.c");
      queue_text(".x");
      queue_text("a..b");
      queue_text("ab.");
      queue_item(8'hFF, 1'b0);
      queue_item(8'h00, 1'b1);
      wait_drained();

      // directed, buffer exactly at the fixed bytes plus name, then one short
      write_reg(dqe_pkg::CSR_QTYPE, 16'd1);
      write_reg(dqe_pkg::CSR_BUF_SIZE, 16'd20);
      @(negedge clock);
      queue_text("ab");
      queue_text("abc");
      wait_drained();

      // random phases: sender light / receiver heavy, then swapped, then no idling
      run_phase(1'b0, 16'hFFFF, 28, 84, 70);
      run_phase(1'b1, 16'h0000, 84, 28, 20);
      run_phase(1'b0, 16'd30, 84, 28, 50);
      run_phase(1'b1, 16'($urandom_range(18, 60)), 0, 0, 45);
      run_phase(1'($urandom_range(1)), dqe_pkg::BUF_RESET, 0, 0, 40);

      $display("sent %0d requests, checked %0d responses over %0d queries (%0d ended in error)",
               reqs_sent, rsps_checked, queries_done, queries_failed);
      $display("both query types, buffer sizes from 0 to 65535, three idle mixes");
      if (fails == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("timed out with %0d writes outstanding", writes_due.size());
      $display("FAIL");
      $finish;
   end

endmodule
